[rtl/smtt_pkg.sv]
package smtt_pkg;

    // Operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_BIND   = 3'd3;
    localparam logic [2:0] OP_ARM    = 3'd4;
    localparam logic [2:0] OP_CANCEL = 3'd5;
    localparam logic [2:0] OP_CALL   = 3'd6;

    // Result kinds
    localparam logic [1:0] K_DONE   = 2'd0;
    localparam logic [1:0] K_ALLOC  = 2'd1;
    localparam logic [1:0] K_EXPIRE = 2'd2;
    localparam logic [1:0] K_CANCEL = 2'd3;

    // Slot states
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [31:0] NEVER      = 32'hffff_ffff;
    localparam int          MAX_EXPIRE = 32;

    typedef struct packed {
        logic [2:0]         operation;
        logic [4:0]         timer_index;
        logic [7:0]         queue_id;
        logic signed [31:0] message;
        logic               auto_cancel;
        logic [31:0]        delay;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         slot;
        logic [7:0]         dest_queue;
        logic signed [31:0] payload;
        logic               ok;
        logic               sched_req;
        logic               last;
    } t_result;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        U_NOP, U_LATCH, U_TICK, U_EXP, U_TFIN, U_ALLOC, U_CHK, U_FIN,
        U_CSCAN, U_CPOST, U_U0, U_UHEAD, U_UWALK, U_I0, U_ILINK, U_IDL, U_IW
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_ctl;

    typedef struct packed {
        logic [2:0] op;
        logic       due;
        logic       exp_stop;
        logic       is_free;
        logic       is_run;
        logic       at_last;
        logic       hit_head;
        logic       link_hit;
        logic       walk_end;
        logic       d_le;
        logic       ti_ok;
        logic       cs_match;
    } t_stat;

endpackage

[rtl/smtt_ctrl.sv]
module smtt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_op,
    input  smtt_pkg::t_stat  i_stat,
    output logic             o_busy,
    output smtt_pkg::t_ctl   o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE, S_TICK, S_TCHK, S_EXP, S_TFIN, S_ALLOC, S_CHK, S_FIN, S_CSCAN,
        S_CPOST, S_U0, S_UHEAD, S_UWALK, S_I0, S_ILINK, S_IDL, S_IW
    } t_state;

    t_state r_state;
    t_state n_ret;

    // Return point after an unlink
    assign n_ret = (i_stat.op == smtt_pkg::OP_CALL) ? S_CPOST : S_FIN;

    assign o_busy = (r_state != S_IDLE);

    // Micro-op per state
    always_comb begin
        unique case (r_state)
            S_IDLE:  o_ctl.uop = i_start ? smtt_pkg::U_LATCH : smtt_pkg::U_NOP;
            S_TICK:  o_ctl.uop = smtt_pkg::U_TICK;
            S_TCHK:  o_ctl.uop = smtt_pkg::U_NOP;
            S_EXP:   o_ctl.uop = smtt_pkg::U_EXP;
            S_TFIN:  o_ctl.uop = smtt_pkg::U_TFIN;
            S_ALLOC: o_ctl.uop = smtt_pkg::U_ALLOC;
            S_CHK:   o_ctl.uop = smtt_pkg::U_CHK;
            S_FIN:   o_ctl.uop = smtt_pkg::U_FIN;
            S_CSCAN: o_ctl.uop = smtt_pkg::U_CSCAN;
            S_CPOST: o_ctl.uop = smtt_pkg::U_CPOST;
            S_U0:    o_ctl.uop = smtt_pkg::U_U0;
            S_UHEAD: o_ctl.uop = smtt_pkg::U_UHEAD;
            S_UWALK: o_ctl.uop = smtt_pkg::U_UWALK;
            S_I0:    o_ctl.uop = smtt_pkg::U_I0;
            S_ILINK: o_ctl.uop = smtt_pkg::U_ILINK;
            S_IDL:   o_ctl.uop = smtt_pkg::U_IDL;
            S_IW:    o_ctl.uop = smtt_pkg::U_IW;
            default: o_ctl.uop = smtt_pkg::U_NOP;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        unique case (i_op) inside
                            smtt_pkg::OP_TICK:  r_state <= S_TICK;
                            smtt_pkg::OP_ALLOC: r_state <= S_ALLOC;
                            smtt_pkg::OP_FREE, smtt_pkg::OP_BIND,
                            smtt_pkg::OP_ARM, smtt_pkg::OP_CANCEL: r_state <= S_CHK;
                            smtt_pkg::OP_CALL:  r_state <= S_CSCAN;
                            default:            r_state <= S_FIN;
                        endcase
                    end
                end
                S_TICK:  r_state <= S_TCHK;
                S_TCHK:  r_state <= i_stat.due ? S_EXP : S_TFIN;
                S_EXP:   if (i_stat.exp_stop) r_state <= S_TFIN;
                S_TFIN:  r_state <= S_IDLE;
                S_ALLOC: if (i_stat.is_free || i_stat.at_last) r_state <= S_IDLE;
                S_CHK: begin
                    if (i_stat.op == smtt_pkg::OP_ARM && i_stat.ti_ok && !i_stat.is_run)
                        r_state <= S_I0;
                    else if ((i_stat.op == smtt_pkg::OP_FREE ||
                              i_stat.op == smtt_pkg::OP_CANCEL) &&
                             i_stat.ti_ok && i_stat.is_run)
                        r_state <= S_U0;
                    else
                        r_state <= S_FIN;
                end
                S_FIN:   r_state <= S_IDLE;
                S_CSCAN: begin
                    if (i_stat.cs_match && i_stat.is_run)
                        r_state <= S_U0;
                    else if (i_stat.at_last)
                        r_state <= S_FIN;
                end
                S_CPOST: r_state <= i_stat.at_last ? S_FIN : S_CSCAN;
                S_U0:    r_state <= i_stat.hit_head ? S_UHEAD : S_UWALK;
                S_UHEAD: r_state <= n_ret;
                S_UWALK: if (i_stat.link_hit || i_stat.walk_end) r_state <= n_ret;
                S_I0:    r_state <= i_stat.d_le ? S_FIN : S_ILINK;
                S_ILINK: r_state <= S_IDL;
                S_IDL: begin
                    if (i_stat.d_le)
                        r_state <= S_IW;
                    else if (i_stat.walk_end)
                        r_state <= S_FIN;
                    else
                        r_state <= S_ILINK;
                end
                S_IW:    r_state <= S_FIN;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/smtt_datapath.sv]
module smtt_datapath #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smtt_pkg::t_cmd_in  i_cmd,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    input  smtt_pkg::t_ctl     i_ctl,
    output smtt_pkg::t_stat    o_stat,
    output smtt_pkg::t_result  o_result,
    output logic               o_result_valid
);

    localparam int IW   = $clog2(TIMER_SLOTS);
    localparam int CMAX = (TIMER_SLOTS > smtt_pkg::MAX_EXPIRE) ? TIMER_SLOTS
                                                               : smtt_pkg::MAX_EXPIRE;
    localparam int CW   = $clog2(CMAX + 1);

    // Slot state (reset) and slot stores (no reset)
    logic [1:0]         r_status [TIMER_SLOTS];
    logic               r_mark   [TIMER_SLOTS];
    logic [7:0]         m_queue  [TIMER_SLOTS];
    logic signed [31:0] m_msg    [TIMER_SLOTS];
    logic [31:0]        m_dl     [TIMER_SLOTS];
    logic [IW-1:0]      m_link   [TIMER_SLOTS];

    logic [IW-1:0] r_head;
    logic [31:0]   r_earliest;
    logic [31:0]   r_tick;
    logic [4:0]    r_task;

    // Per-transaction working registers
    logic [2:0]         r_op;
    logic [4:0]         r_ti;
    logic [7:0]         r_qid;
    logic signed [31:0] r_msg;
    logic               r_ac;
    logic [31:0]        r_dly;
    logic [IW-1:0]      r_addr;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_nidx;
    logic [IW-1:0]      r_p;
    logic [CW-1:0]      r_cnt;
    logic [31:0]        r_d;
    logic               r_ok;
    logic               r_ts;

    smtt_pkg::t_result  r_res;
    logic               r_res_valid;

    logic [1:0]         rd_stat;
    logic               rd_mark;
    logic [7:0]         rd_queue;
    logic signed [31:0] rd_msg;
    logic [IW-1:0]      rd_link;
    logic [31:0]        rd_dl;
    logic [31:0]        arm_dl;

    logic               st_we, mark_we, link_we, dl_we, qm_we;
    logic [IW-1:0]      st_wa, mark_wa, link_wa;
    logic [1:0]         st_wd;
    logic               mark_wd;
    logic [IW-1:0]      link_wd;

    function automatic smtt_pkg::t_result mk_res(
        input logic [1:0] kind, input logic [4:0] slot, input logic [7:0] q,
        input logic signed [31:0] pay, input logic ok, input logic ts, input logic last
    );
        smtt_pkg::t_result r;
        r.kind        = kind;
        r.slot        = slot;
        r.dest_queue  = q;
        r.payload     = pay;
        r.ok          = ok;
        r.sched_req   = ts;
        r.last        = last;
        return r;
    endfunction

    // Single read port at the working address; the sentinel deadline is fixed
    assign rd_stat  = r_status[r_addr];
    assign rd_mark  = r_mark[r_addr];
    assign rd_queue = m_queue[r_addr];
    assign rd_msg   = m_msg[r_addr];
    assign rd_link  = m_link[r_addr];
    assign rd_dl    = (r_addr == '0) ? smtt_pkg::NEVER : m_dl[r_addr];
    assign arm_dl   = r_tick + r_dly;

    // Status flags to the controller
    always_comb begin
        o_stat.op       = r_op;
        o_stat.due      = (r_earliest <= r_tick);
        o_stat.exp_stop = (r_addr == '0) || (rd_dl > r_tick) ||
                          (r_cnt == CW'(smtt_pkg::MAX_EXPIRE));
        o_stat.is_free  = (rd_stat == smtt_pkg::ST_FREE);
        o_stat.is_run   = (rd_stat == smtt_pkg::ST_RUN);
        o_stat.at_last  = (r_addr == IW'(TIMER_SLOTS - 1));
        o_stat.hit_head = (r_head == r_idx);
        o_stat.link_hit = (rd_link == r_idx);
        o_stat.walk_end = (r_cnt == CW'(TIMER_SLOTS - 1));
        o_stat.d_le     = (r_d <= rd_dl);
        o_stat.ti_ok    = (r_ti != 5'd0) && ({27'd0, r_ti} < 32'(TIMER_SLOTS));
        o_stat.cs_match = (rd_stat != smtt_pkg::ST_FREE) && rd_mark && (rd_queue == r_qid);
    end

    // Store write selection
    always_comb begin
        st_we   = 1'b0;
        st_wa   = r_addr;
        st_wd   = smtt_pkg::ST_FREE;
        mark_we = 1'b0;
        mark_wa = r_addr;
        mark_wd = 1'b0;
        link_we = 1'b0;
        link_wa = r_addr;
        link_wd = r_nidx;
        dl_we   = 1'b0;
        qm_we   = 1'b0;
        case (i_ctl.uop)
            smtt_pkg::U_EXP: begin
                if (!o_stat.exp_stop) begin
                    st_we = 1'b1;
                    st_wd = smtt_pkg::ST_ALLOC;
                end
            end
            smtt_pkg::U_ALLOC: begin
                if (o_stat.is_free) begin
                    st_we   = 1'b1;
                    st_wd   = smtt_pkg::ST_ALLOC;
                    mark_we = 1'b1;
                end
            end
            smtt_pkg::U_CHK: begin
                if (r_op == smtt_pkg::OP_ARM && o_stat.ti_ok && !o_stat.is_run) begin
                    st_we = 1'b1;
                    st_wa = r_idx;
                    st_wd = smtt_pkg::ST_RUN;
                    dl_we = 1'b1;
                end
            end
            smtt_pkg::U_FIN: begin
                if (r_ok) begin
                    case (r_op)
                        smtt_pkg::OP_BIND: begin
                            qm_we   = 1'b1;
                            mark_we = 1'b1;
                            mark_wa = r_idx;
                            mark_wd = r_ac;
                        end
                        smtt_pkg::OP_FREE: begin
                            st_we = 1'b1;
                            st_wa = r_idx;
                        end
                        smtt_pkg::OP_CANCEL: begin
                            st_we = 1'b1;
                            st_wa = r_idx;
                            st_wd = smtt_pkg::ST_ALLOC;
                        end
                        default: ;
                    endcase
                end
            end
            smtt_pkg::U_CSCAN: begin
                if (o_stat.cs_match && !o_stat.is_run)
                    st_we = 1'b1;
            end
            smtt_pkg::U_CPOST: begin
                st_we = 1'b1;
                st_wa = r_idx;
            end
            smtt_pkg::U_UWALK: begin
                if (o_stat.link_hit)
                    link_we = 1'b1;
            end
            smtt_pkg::U_I0: begin
                if (o_stat.d_le) begin
                    link_we = 1'b1;
                    link_wa = r_idx;
                    link_wd = r_addr;
                end
            end
            smtt_pkg::U_IDL: begin
                if (o_stat.d_le) begin
                    link_we = 1'b1;
                    link_wa = r_p;
                    link_wd = r_idx;
                end
            end
            smtt_pkg::U_IW: begin
                link_we = 1'b1;
                link_wa = r_idx;
            end
            default: ;
        endcase
    end

    // Slot stores without reset
    always_ff @(posedge i_clk) begin
        if (link_we)
            m_link[link_wa] <= link_wd;
        if (dl_we)
            m_dl[r_idx] <= arm_dl;
        if (qm_we) begin
            m_queue[r_idx] <= r_qid;
            m_msg[r_idx]   <= r_msg;
        end
    end

    // Slot state with reset: all free, sentinel running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                r_status[i] <= (i == 0) ? smtt_pkg::ST_RUN : smtt_pkg::ST_FREE;
                r_mark[i]   <= 1'b0;
            end
        end else begin
            if (st_we)
                r_status[st_wa] <= st_wd;
            if (mark_we)
                r_mark[mark_wa] <= mark_wd;
        end
    end

    // List head, counters, working registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_earliest  <= smtt_pkg::NEVER;
            r_tick      <= '0;
            r_task      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_we)
                r_task <= i_cfg_data;
            case (i_ctl.uop)
                smtt_pkg::U_LATCH: begin
                    r_op  <= i_cmd.operation;
                    r_ti  <= i_cmd.timer_index;
                    r_qid <= i_cmd.queue_id;
                    r_msg <= i_cmd.message;
                    r_ac  <= i_cmd.auto_cancel;
                    r_dly <= i_cmd.delay;
                    r_idx <= IW'(i_cmd.timer_index);
                    r_ok  <= 1'b0;
                    r_ts  <= 1'b0;
                    r_cnt <= '0;
                    if (i_cmd.operation == smtt_pkg::OP_ALLOC)
                        r_addr <= '0;
                    else if (i_cmd.operation == smtt_pkg::OP_CALL)
                        r_addr <= IW'(1);
                    else
                        r_addr <= IW'(i_cmd.timer_index);
                end
                smtt_pkg::U_TICK: begin
                    r_tick <= r_tick + 32'd1;
                    r_addr <= r_head;
                    r_cnt  <= '0;
                end
                smtt_pkg::U_EXP: begin
                    if (o_stat.exp_stop) begin
                        r_earliest <= rd_dl;
                    end else begin
                        r_head <= rd_link;
                        r_addr <= rd_link;
                        r_cnt  <= r_cnt + CW'(1);
                        if (32'(r_addr) == 32'(r_task)) begin
                            r_ts <= 1'b1;
                        end else begin
                            r_res_valid <= 1'b1;
                            r_res <= mk_res(smtt_pkg::K_EXPIRE, 5'(r_addr), rd_queue,
                                            rd_msg, 1'b0, 1'b0, 1'b0);
                        end
                    end
                end
                smtt_pkg::U_TFIN: begin
                    r_res_valid <= 1'b1;
                    r_res <= mk_res(smtt_pkg::K_DONE, 5'd0, 8'd0, 32'sd0, 1'b0, r_ts, 1'b1);
                end
                smtt_pkg::U_ALLOC: begin
                    if (o_stat.is_free) begin
                        r_res_valid <= 1'b1;
                        r_res <= mk_res(smtt_pkg::K_ALLOC, 5'(r_addr), 8'd0, 32'sd0,
                                        1'b1, 1'b0, 1'b1);
                    end else if (o_stat.at_last) begin
                        r_res_valid <= 1'b1;
                        r_res <= mk_res(smtt_pkg::K_ALLOC, 5'd0, 8'd0, 32'sd0,
                                        1'b0, 1'b0, 1'b1);
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                smtt_pkg::U_CHK: begin
                    case (r_op)
                        smtt_pkg::OP_ARM: begin
                            r_ok <= o_stat.ti_ok && !o_stat.is_run;
                            r_d    <= arm_dl;
                            r_addr <= r_head;
                        end
                        smtt_pkg::OP_CANCEL: r_ok <= o_stat.ti_ok && o_stat.is_run;
                        default:             r_ok <= o_stat.ti_ok;
                    endcase
                end
                smtt_pkg::U_FIN: begin
                    r_res_valid <= 1'b1;
                    case (r_op) inside
                        smtt_pkg::OP_CANCEL:
                            r_res <= mk_res(smtt_pkg::K_CANCEL, r_ti, 8'd0, 32'sd0,
                                            r_ok, 1'b0, 1'b1);
                        smtt_pkg::OP_FREE, smtt_pkg::OP_BIND, smtt_pkg::OP_ARM:
                            r_res <= mk_res(smtt_pkg::K_DONE, r_ti, 8'd0, 32'sd0,
                                            r_ok, 1'b0, 1'b1);
                        default:
                            r_res <= mk_res(smtt_pkg::K_DONE, 5'd0, 8'd0, 32'sd0,
                                            r_ok, 1'b0, 1'b1);
                    endcase
                end
                smtt_pkg::U_CSCAN: begin
                    if (o_stat.cs_match && o_stat.is_run) begin
                        r_idx <= r_addr;
                    end else begin
                        if (o_stat.cs_match)
                            r_ok <= 1'b1;
                        if (!o_stat.at_last)
                            r_addr <= r_addr + IW'(1);
                    end
                end
                smtt_pkg::U_CPOST: begin
                    r_ok <= 1'b1;
                    if (!o_stat.at_last)
                        r_addr <= r_addr + IW'(1);
                end
                smtt_pkg::U_U0: begin
                    r_nidx <= rd_link;
                    r_cnt  <= '0;
                    if (o_stat.hit_head) begin
                        r_head <= rd_link;
                        r_addr <= rd_link;
                    end else begin
                        r_addr <= r_head;
                    end
                end
                smtt_pkg::U_UHEAD: begin
                    r_earliest <= rd_dl;
                    r_addr     <= r_idx;
                end
                smtt_pkg::U_UWALK: begin
                    if (o_stat.link_hit || o_stat.walk_end) begin
                        r_addr <= r_idx;
                    end else begin
                        r_addr <= rd_link;
                        r_cnt  <= r_cnt + CW'(1);
                    end
                end
                smtt_pkg::U_I0: begin
                    r_cnt <= '0;
                    if (o_stat.d_le) begin
                        r_head     <= r_idx;
                        r_earliest <= r_d;
                    end
                end
                smtt_pkg::U_ILINK: begin
                    r_p    <= r_addr;
                    r_addr <= rd_link;
                end
                smtt_pkg::U_IDL: begin
                    if (o_stat.d_le)
                        r_nidx <= r_addr;
                    else
                        r_cnt <= r_cnt + CW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_valid;

endmodule

[rtl/sorted_multi_timer_table.sv]
// Channel   | Ports                              | Transaction
// ----------+------------------------------------+----------------------------------
// command   | i_start, o_busy, i_cmd             | taken when i_start & !o_busy
// result    | o_result_valid, o_result           | one cycle per strobe, no backpressure
// config    | i_cfg_we, i_cfg_data               | task timer slot, written on i_cfg_we
//
// One command at a time; o_busy falls in the cycle its last result is on o_result.
// Tick: when a timer is due, one expiry step per expired timer plus a stop step.
// Alloc and cancel-all scan the slots, one per cycle, with cancel-all pausing to
// unlink each running match; list insert walks a link and a compare step per entry;
// unlink one step plus one per entry walked; worst: cancel-all unlinking every timer.
// Synchronous active-low reset: all slots free, sentinel slot 0 running; no stalls.
module sorted_multi_timer_table #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  smtt_pkg::t_cmd_in  i_cmd,
    output logic               o_result_valid,
    output smtt_pkg::t_result  o_result,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);

    smtt_pkg::t_ctl  ctl;
    smtt_pkg::t_stat stat;

    // Sequencer
    smtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_cmd.operation),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_ctl   (ctl)
    );

    // Slot stores and list registers
    smtt_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

[verif/sorted_multi_timer_table_test.sv]
module sorted_multi_timer_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    smtt_pkg::t_cmd_in    i_cmd;
    logic                 o_result_valid;
    smtt_pkg::t_result    o_result;
    logic                 i_cfg_we;
    logic [4:0]           i_cfg_data;

    sorted_multi_timer_table #(.TIMER_SLOTS(SLOTS)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Shadow of the timer table
    logic [1:0]  tm_status   [SLOTS];
    logic        tm_cmark    [SLOTS];
    logic [7:0]  tm_queue    [SLOTS];
    logic [31:0] tm_message  [SLOTS];
    logic [31:0] tm_deadline [SLOTS];
    logic [4:0]  tm_link     [SLOTS];
    bit          tm_bound    [SLOTS];
    logic [4:0]  tm_head;
    logic [31:0] tm_earliest;
    logic [31:0] tm_ticks;
    logic [4:0]  tm_task_slot;

    smtt_pkg::t_result expected_results[$];
    smtt_pkg::t_result fresh[$];
    int mismatches, n_items, n_expiries, n_switches, n_results;
    int burst_left;

    function automatic smtt_pkg::t_result make_result(logic [1:0] kind, logic [4:0] slot,
                                                      logic [7:0] q, logic [31:0] pay,
                                                      logic ok, logic ts, logic last);
        smtt_pkg::t_result r;
        r.kind = kind; r.slot = slot; r.dest_queue = q; r.payload = pay;
        r.ok = ok; r.sched_req = ts; r.last = last;
        return r;
    endfunction

    function automatic smtt_pkg::t_cmd_in make_cmd(logic [2:0] op, logic [4:0] idx,
                                                   logic [7:0] q, logic [31:0] msg,
                                                   logic ac, logic [31:0] dly);
        smtt_pkg::t_cmd_in c;
        c.operation = op; c.timer_index = idx; c.queue_id = q;
        c.message = msg; c.auto_cancel = ac; c.delay = dly;
        return c;
    endfunction

    function automatic void unlink_timer(logic [4:0] idx);
        logic [4:0] p;
        if (tm_head == idx) begin
            tm_head = tm_link[idx];
            tm_earliest = tm_deadline[tm_head];
            return;
        end
        p = tm_head;
        for (int n = 0; n < SLOTS; n++) begin
            if (tm_link[p] == idx) begin
                tm_link[p] = tm_link[idx];
                return;
            end
            p = tm_link[p];
        end
    endfunction

    function automatic void insert_timer(logic [4:0] idx);
        logic [31:0] d;
        logic [4:0] p, q;
        d = tm_deadline[idx];
        p = tm_head;
        if (d <= tm_deadline[p]) begin
            tm_link[idx] = p;
            tm_head = idx;
            tm_earliest = d;
            return;
        end
        for (int n = 0; n < SLOTS; n++) begin
            q = tm_link[p];
            if (d <= tm_deadline[q]) begin
                tm_link[p] = idx;
                tm_link[idx] = q;
                return;
            end
            p = q;
        end
    endfunction

    // Computes the results of one command into fresh and updates the shadow
    function automatic void predict_timer_op(smtt_pkg::t_cmd_in c);
        logic [4:0] ti, h;
        logic ok, ts, valid;
        ti = c.timer_index;
        valid = (ti != 5'd0);
        ok = 0;
        ts = 0;
        fresh.delete();
        case (c.operation)
            smtt_pkg::OP_TICK: begin
                tm_ticks++;
                if (tm_earliest <= tm_ticks) begin
                    for (int i = 0; i < smtt_pkg::MAX_EXPIRE; i++) begin
                        h = tm_head;
                        if (h == 5'd0 || tm_deadline[h] > tm_ticks) break;
                        tm_status[h] = smtt_pkg::ST_ALLOC;
                        tm_head = tm_link[h];
                        if (h == tm_task_slot) ts = 1;
                        else fresh.push_back(make_result(smtt_pkg::K_EXPIRE, h, tm_queue[h],
                                                         tm_message[h], 0, 0, 1'b0));
                    end
                    tm_earliest = tm_deadline[tm_head];
                end
                fresh.push_back(make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, ts, 1));
            end
            smtt_pkg::OP_ALLOC: begin
                h = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (tm_status[i] == smtt_pkg::ST_FREE) begin
                        h = 5'(i); ok = 1;
                        tm_status[i] = smtt_pkg::ST_ALLOC;
                        tm_cmark[i] = 0;
                        break;
                    end
                end
                fresh.push_back(make_result(smtt_pkg::K_ALLOC, h, 0, 0, ok, 0, 1));
            end
            smtt_pkg::OP_FREE: begin
                if (valid) begin
                    if (tm_status[ti] == smtt_pkg::ST_RUN) unlink_timer(ti);
                    tm_status[ti] = smtt_pkg::ST_FREE;
                    ok = 1;
                end
                fresh.push_back(make_result(smtt_pkg::K_DONE, ti, 0, 0, ok, 0, 1));
            end
            smtt_pkg::OP_BIND: begin
                if (valid) begin
                    tm_queue[ti] = c.queue_id;
                    tm_message[ti] = c.message;
                    tm_cmark[ti] = c.auto_cancel;
                    tm_bound[ti] = 1;
                    ok = 1;
                end
                fresh.push_back(make_result(smtt_pkg::K_DONE, ti, 0, 0, ok, 0, 1));
            end
            smtt_pkg::OP_ARM: begin
                if (valid && tm_status[ti] != smtt_pkg::ST_RUN) begin
                    tm_deadline[ti] = tm_ticks + c.delay;
                    tm_status[ti] = smtt_pkg::ST_RUN;
                    insert_timer(ti);
                    ok = 1;
                end
                fresh.push_back(make_result(smtt_pkg::K_DONE, ti, 0, 0, ok, 0, 1));
            end
            smtt_pkg::OP_CANCEL: begin
                if (valid && tm_status[ti] == smtt_pkg::ST_RUN) begin
                    unlink_timer(ti);
                    tm_status[ti] = smtt_pkg::ST_ALLOC;
                    ok = 1;
                end
                fresh.push_back(make_result(smtt_pkg::K_CANCEL, ti, 0, 0, ok, 0, 1));
            end
            smtt_pkg::OP_CALL: begin
                for (int i = 1; i < SLOTS; i++) begin
                    if (tm_status[i] != smtt_pkg::ST_FREE && tm_cmark[i] &&
                        tm_queue[i] == c.queue_id) begin
                        if (tm_status[i] == smtt_pkg::ST_RUN) unlink_timer(5'(i));
                        tm_status[i] = smtt_pkg::ST_FREE;
                        ok = 1;
                    end
                end
                fresh.push_back(make_result(smtt_pkg::K_DONE, 0, 0, 0, ok, 0, 1));
            end
            default: fresh.push_back(make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, 0, 1));
        endcase
    endfunction

    // Result checker: no backpressure, every strobe is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_result);
            end else begin
                smtt_pkg::t_result want;
                want = expected_results.pop_front();
                if (o_result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    task automatic idle_cycles(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Presents one command and waits for it to be taken
    task automatic issue(smtt_pkg::t_cmd_in c, bit typed, smtt_pkg::t_result want);
        i_start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (o_busy);
        predict_timer_op(c);
        n_items++;
        foreach (fresh[i]) begin
            if (fresh[i].kind == smtt_pkg::K_EXPIRE) n_expiries++;
            if (fresh[i].sched_req) n_switches++;
        end
        if (typed) expected_results.push_back(want);
        else foreach (fresh[i]) expected_results.push_back(fresh[i]);
        // bursts of back-to-back commands separated by random gaps
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            idle_cycles($urandom_range(1, 8));
        end
    endtask

    task automatic run(smtt_pkg::t_cmd_in c);
        issue(c, 0, '0);
    endtask

    // Drains all results, then lets the block settle before a register write
    task automatic drain_and_configure(logic [4:0] slot);
        idle_cycles(1);
        while (expected_results.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= slot;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tm_task_slot = slot;
    endtask

    function automatic smtt_pkg::t_cmd_in random_cmd();
        int pick;
        logic [4:0] idx;
        logic [7:0] q;
        logic [31:0] dly;
        pick = $urandom_range(0, 99);
        idx = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, SLOTS - 1));
        q = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        dly = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
        if (pick < 25)
            return make_cmd(smtt_pkg::OP_TICK, 5'($urandom), q, $urandom, 1'($urandom),
                            $urandom);
        if (pick < 40)
            return make_cmd(smtt_pkg::OP_ALLOC, 5'($urandom), q, $urandom, 1'($urandom),
                            $urandom);
        if (pick < 55 || (pick < 75 && idx != 0 && !tm_bound[idx]))
            return make_cmd(smtt_pkg::OP_BIND, idx, q, $urandom, 1'($urandom), $urandom);
        if (pick < 75)
            return make_cmd(smtt_pkg::OP_ARM, idx, q, $urandom, 1'($urandom), dly);
        if (pick < 83)
            return make_cmd(smtt_pkg::OP_CANCEL, idx, q, $urandom, 1'($urandom), $urandom);
        if (pick < 90)
            return make_cmd(smtt_pkg::OP_FREE, idx, q, $urandom, 1'($urandom), $urandom);
        if (pick < 96)
            return make_cmd(smtt_pkg::OP_CALL, idx, q, $urandom, 1'($urandom), $urandom);
        return make_cmd(OP_UNUSED, idx, q, $urandom, 1'($urandom), $urandom);
    endfunction

    typedef struct {
        smtt_pkg::t_cmd_in cmd;
        bit                typed;
        smtt_pkg::t_result want;
    } t_row;

    t_row directed[$];

    function automatic void add_row(smtt_pkg::t_cmd_in c, bit typed,
                                    smtt_pkg::t_result want);
        t_row r;
        r.cmd = c; r.typed = typed; r.want = want;
        directed.push_back(r);
    endfunction

    initial begin
        logic [4:0] task_slots[4];
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatches = 0; n_items = 0; n_expiries = 0; n_switches = 0; n_results = 0;
        burst_left = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tm_status[i] = smtt_pkg::ST_FREE; tm_cmark[i] = 0; tm_queue[i] = 0;
            tm_message[i] = 0; tm_deadline[i] = 0; tm_link[i] = 0; tm_bound[i] = 0;
        end
        tm_status[0] = smtt_pkg::ST_RUN;
        tm_deadline[0] = smtt_pkg::NEVER;
        tm_head = 0; tm_earliest = smtt_pkg::NEVER; tm_ticks = 0; tm_task_slot = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, rejections
        add_row(make_cmd(smtt_pkg::OP_ALLOC, 0, 0, 0, 0, 0), 1,
                make_result(smtt_pkg::K_ALLOC, 1, 0, 0, 1, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_ALLOC, 31, 8'hff, 32'hffff_ffff, 1, 32'hffff_ffff), 1,
                make_result(smtt_pkg::K_ALLOC, 2, 0, 0, 1, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_BIND, 1, 8'hff, 32'h8000_0000, 1, 0), 1,
                make_result(smtt_pkg::K_DONE, 1, 0, 0, 1, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_BIND, 2, 0, 32'h7fff_ffff, 0, 0), 1,
                make_result(smtt_pkg::K_DONE, 2, 0, 0, 1, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_BIND, 0, 8'h55, 32'h1234, 1, 0), 1,
                make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_ARM, 1, 0, 0, 0, 2), 1,
                make_result(smtt_pkg::K_DONE, 1, 0, 0, 1, 0, 1));
        // arming a running timer is refused
        add_row(make_cmd(smtt_pkg::OP_ARM, 1, 0, 0, 0, 5), 1,
                make_result(smtt_pkg::K_DONE, 1, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_ARM, 0, 0, 0, 0, 5), 1,
                make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_ARM, 2, 0, 0, 0, 0), 1,
                make_result(smtt_pkg::K_DONE, 2, 0, 0, 1, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_TICK, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_CANCEL, 1, 0, 0, 0, 0), 1,
                make_result(smtt_pkg::K_CANCEL, 1, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_ARM, 2, 0, 0, 0, 3), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_CANCEL, 2, 0, 0, 0, 0), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_ARM, 1, 0, 0, 0, 32'hffff_ffff), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_ARM, 2, 0, 0, 0, 32'h0000_0004), 0, '0);
        // free while running unlinks first
        add_row(make_cmd(smtt_pkg::OP_FREE, 1, 0, 0, 0, 0), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_BIND, 2, 8'hff, 32'hdead_beef, 1, 0), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_CALL, 0, 8'hff, 0, 0, 0), 0, '0);
        add_row(make_cmd(smtt_pkg::OP_CALL, 0, 8'hff, 0, 0, 0), 1,
                make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, 0, 1));
        add_row(make_cmd(OP_UNUSED, 31, 8'hff, 32'hffff_ffff, 1, 32'hffff_ffff), 1,
                make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_FREE, 0, 0, 0, 0, 0), 1,
                make_result(smtt_pkg::K_DONE, 0, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_CANCEL, 0, 0, 0, 0, 0), 1,
                make_result(smtt_pkg::K_CANCEL, 0, 0, 0, 0, 0, 1));
        add_row(make_cmd(smtt_pkg::OP_FREE, 31, 0, 0, 0, 0), 1,
                make_result(smtt_pkg::K_DONE, 31, 0, 0, 1, 0, 1));
        foreach (directed[i]) issue(directed[i].cmd, directed[i].typed, directed[i].want);

        // Random phases, each under its own task timer slot
        task_slots[0] = 5'd31;
        task_slots[1] = 5'd1;
        task_slots[2] = 5'($urandom_range(2, 30));
        task_slots[3] = 5'd0;
        for (int p = 0; p < 4; p++) begin
            drain_and_configure(task_slots[p]);
            // fill the table and expire many timers on one tick
            if (p == 1) begin
                for (int i = 0; i < SLOTS; i++)
                    run(make_cmd(smtt_pkg::OP_ALLOC, 0, 0, 0, 0, 0));
                for (int i = 1; i < SLOTS; i++) begin
                    run(make_cmd(smtt_pkg::OP_BIND, 5'(i), 8'($urandom_range(0, 3)),
                                 $urandom, 1'($urandom), 0));
                    run(make_cmd(smtt_pkg::OP_ARM, 5'(i), 0, 0, 0,
                                 32'($urandom_range(1, 2))));
                end
                repeat (3) run(make_cmd(smtt_pkg::OP_TICK, 0, 0, 0, 0, 0));
            end
            for (int i = 0; i < 22; i++) run(random_cmd());
        end

        idle_cycles(1);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        mismatches += expected_results.size();

        $display("%0d commands, %0d results checked, %0d expiries, %0d task switches",
                 n_items, n_results, n_expiries, n_switches);
        $display("task timer slots used: 31, 1, random, none; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sorted_multi_timer_table.f]
rtl/smtt_pkg.sv
rtl/smtt_ctrl.sv
rtl/smtt_datapath.sv
rtl/sorted_multi_timer_table.sv
verif/sorted_multi_timer_table_test.sv
